// ===== rtl/iir_fourth_order_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// iir filter assertion macros
// shared concurrent assertion forms used by the filter rtl
// ----------------------------------------------------------------------------
`ifndef IIR_FOURTH_ORDER_FILTER_TOP_DEFINES_SVH
`define IIR_FOURTH_ORDER_FILTER_TOP_DEFINES_SVH

// condition implies check in the same cycle
`define IIRF_ASSERT_SAME(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error(msg);

// condition implies check in the following cycle
`define IIRF_ASSERT_NEXT(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error(msg);

`endif

// ===== rtl/iirf_pkg.sv =====
// ----------------------------------------------------------------------------
// iirf_pkg
// shared widths, register map and coefficient bundle for the iir filter
// ----------------------------------------------------------------------------
package iirf_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 28;
   localparam int TAPS           = 4;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   // nine products plus the rounding term need four guard bits
   localparam int ACC_BITS  = PROD_BITS + 4;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int REG_IDX_BITS  = 3;
   localparam int REG_LSB       = 3;

   localparam logic [CSR_DATA_BITS-1:0] COEF_B0_B1_RESET = 64'h1000_0000_0000_0000;

   localparam logic signed [ACC_BITS-1:0] ROUND_CONST =
      ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));

   typedef enum logic [REG_IDX_BITS-1:0] {
      REG_B0_B1 = 3'd0,
      REG_B2_B3 = 3'd1,
      REG_B4_A1 = 3'd2,
      REG_A2_A3 = 3'd3,
      REG_A4    = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [TAPS:0][COEF_BITS-1:0]   b;
      logic [TAPS-1:0][COEF_BITS-1:0] a;
   } coef_type;

endpackage

// ===== rtl/iir_fourth_order_filter_top.sv =====
// ----------------------------------------------------------------------------
// iir_fourth_order_filter_top
// fourth-order direct form i iir filter with apb-style coefficient port
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one signed sample per beat, rsp channel returns one
//   filtered, saturated sample per accepted beat, in order. both channels use
//   valid/stall; a beat moves when valid is high and stall is low.
//   the csr port holds nine signed q4.28 coefficients packed in pairs into
//   64-bit registers at byte addresses 0, 8, 16, 24 and a4 alone at 32.
//   write coefficients only while no sample is in flight.
// a sample waits in the input register, its result in the result register.
// throughput: one sample per cycle while rsp_stall is low; the output history
//   loop through four multipliers and the adder tree sets the clock limit.
// reset: history clears to zero, coefficients return to b0 = 1.0 with all
//   others zero (pass-through), and both channels go empty.
// stall: a stalled result holds in the result register; at most one more
//   sample is taken into the input register, after which req_stall rises.
// ----------------------------------------------------------------------------
module iir_fourth_order_filter_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [iirf_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [iirf_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [iirf_pkg::CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [iirf_pkg::CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [iirf_pkg::CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                                     csr_pready
);

   iirf_pkg::coef_type coef;

   iirf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   iirf_core u_core (
      .clock          (clock),
      .reset          (reset),
      .coef           (coef),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ===== rtl/iirf_csr.sv =====
// ----------------------------------------------------------------------------
// iirf_csr
// coefficient register file behind the apb-style configuration port
// ----------------------------------------------------------------------------
module iirf_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [iirf_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [iirf_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [iirf_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                   csr_pready,
   output iirf_pkg::coef_type                     coef
);

   logic [iirf_pkg::CSR_DATA_BITS-1:0] b0_b1_ff, b0_b1_in;
   logic [iirf_pkg::CSR_DATA_BITS-1:0] b2_b3_ff, b2_b3_in;
   logic [iirf_pkg::CSR_DATA_BITS-1:0] b4_a1_ff, b4_a1_in;
   logic [iirf_pkg::CSR_DATA_BITS-1:0] a2_a3_ff, a2_a3_in;
   logic [iirf_pkg::COEF_BITS-1:0]     a4_ff, a4_in;
   logic                               wr_en;
   iirf_pkg::reg_idx_type              reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = iirf_pkg::reg_idx_type'(
      csr_paddr[iirf_pkg::REG_LSB +: iirf_pkg::REG_IDX_BITS]);

   always_comb begin
      b0_b1_in = b0_b1_ff;
      b2_b3_in = b2_b3_ff;
      b4_a1_in = b4_a1_ff;
      a2_a3_in = a2_a3_ff;
      a4_in    = a4_ff;
      if (wr_en) begin
         case (reg_idx)
            iirf_pkg::REG_B0_B1: b0_b1_in = csr_pwdata;
            iirf_pkg::REG_B2_B3: b2_b3_in = csr_pwdata;
            iirf_pkg::REG_B4_A1: b4_a1_in = csr_pwdata;
            iirf_pkg::REG_A2_A3: a2_a3_in = csr_pwdata;
            iirf_pkg::REG_A4:    a4_in    = csr_pwdata[iirf_pkg::COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_b1_ff <= iirf_pkg::COEF_B0_B1_RESET;
         b2_b3_ff <= '0;
         b4_a1_ff <= '0;
         a2_a3_ff <= '0;
         a4_ff    <= '0;
      end else begin
         b0_b1_ff <= b0_b1_in;
         b2_b3_ff <= b2_b3_in;
         b4_a1_ff <= b4_a1_in;
         a2_a3_ff <= a2_a3_in;
         a4_ff    <= a4_in;
      end
   end

   always_comb begin
      case (reg_idx)
         iirf_pkg::REG_B0_B1: csr_prdata = b0_b1_ff;
         iirf_pkg::REG_B2_B3: csr_prdata = b2_b3_ff;
         iirf_pkg::REG_B4_A1: csr_prdata = b4_a1_ff;
         iirf_pkg::REG_A2_A3: csr_prdata = a2_a3_ff;
         iirf_pkg::REG_A4:    csr_prdata = iirf_pkg::CSR_DATA_BITS'(a4_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // high half holds the first-named coefficient of each pair
   assign coef.b[0] = b0_b1_ff[63:32];
   assign coef.b[1] = b0_b1_ff[31:0];
   assign coef.b[2] = b2_b3_ff[63:32];
   assign coef.b[3] = b2_b3_ff[31:0];
   assign coef.b[4] = b4_a1_ff[63:32];
   assign coef.a[0] = b4_a1_ff[31:0];
   assign coef.a[1] = a2_a3_ff[63:32];
   assign coef.a[2] = a2_a3_ff[31:0];
   assign coef.a[3] = a4_ff;

endmodule

// ===== rtl/iirf_core.sv =====
// ----------------------------------------------------------------------------
// iirf_core
// sample register, nine-term multiply-accumulate, rounding, saturation,
// history registers and result register
// ----------------------------------------------------------------------------
`include "iir_fourth_order_filter_top_defines.svh"

module iirf_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  iirf_pkg::coef_type                       coef,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [iirf_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [iirf_pkg::SAMPLE_BITS-1:0]  rsp_sample_out
);

   localparam int SB = iirf_pkg::SAMPLE_BITS;
   localparam int AB = iirf_pkg::ACC_BITS;
   localparam int PB = iirf_pkg::PROD_BITS;
   localparam int NT = iirf_pkg::TAPS;

   logic signed [SB-1:0] x_ff, x_in;
   logic                 x_vld_ff, x_vld_in;
   logic signed [SB-1:0] xh_ff [NT];
   logic signed [SB-1:0] xh_in [NT];
   logic signed [SB-1:0] yh_ff [NT];
   logic signed [SB-1:0] yh_in [NT];
   logic signed [SB-1:0] y_ff, y_in;
   logic                 y_vld_ff, y_vld_in;

   logic                 advance;
   logic                 req_take;
   logic                 compute;
   logic signed [PB-1:0] prod_b [NT+1];
   logic signed [PB-1:0] prod_a [NT];
   logic signed [AB-1:0] acc;
   logic signed [AB-1:0] shifted;
   logic [AB-SB:0]       top_bits;
   logic signed [SB-1:0] y_sat;

   // result register frees up when empty or its beat is taken
   assign advance   = !y_vld_ff || !rsp_stall;
   assign req_stall = x_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign compute   = x_vld_ff && advance;

   always_comb begin
      prod_b[0] = x_ff * $signed(coef.b[0]);
      for (int k = 0; k < NT; k++) begin
         prod_b[k+1] = xh_ff[k] * $signed(coef.b[k+1]);
         prod_a[k]   = yh_ff[k] * $signed(coef.a[k]);
      end
   end

   always_comb begin
      acc = AB'(prod_b[0]) + iirf_pkg::ROUND_CONST;
      for (int k = 0; k < NT; k++) begin
         acc = acc + AB'(prod_b[k+1]) - AB'(prod_a[k]);
      end
   end

   // in range when every bit from the sample msb upward matches the sign
   always_comb begin
      shifted  = acc >>> iirf_pkg::COEF_FRAC_BITS;
      top_bits = shifted[AB-1:SB-1];
      if ((&top_bits) || !(|top_bits)) begin
         y_sat = shifted[SB-1:0];
      end else begin
         y_sat = {shifted[AB-1], {(SB-1){~shifted[AB-1]}}};
      end
   end

   always_comb begin
      x_in     = req_take ? req_sample_in : x_ff;
      x_vld_in = req_take ? 1'b1 : (advance ? 1'b0 : x_vld_ff);
      y_in     = compute ? y_sat : y_ff;
      y_vld_in = compute ? 1'b1 : (advance ? 1'b0 : y_vld_ff);
      for (int k = 0; k < NT; k++) begin
         xh_in[k] = xh_ff[k];
         yh_in[k] = yh_ff[k];
      end
      if (compute) begin
         xh_in[0] = x_ff;
         yh_in[0] = y_sat;
         for (int k = 1; k < NT; k++) begin
            xh_in[k] = xh_ff[k-1];
            yh_in[k] = yh_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
         y_vld_ff <= 1'b0;
         for (int k = 0; k < NT; k++) begin
            xh_ff[k] <= '0;
            yh_ff[k] <= '0;
         end
      end else begin
         x_vld_ff <= x_vld_in;
         y_vld_ff <= y_vld_in;
         for (int k = 0; k < NT; k++) begin
            xh_ff[k] <= xh_in[k];
            yh_ff[k] <= yh_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign rsp_valid      = y_vld_ff;
   assign rsp_sample_out = y_ff;

   `IIRF_ASSERT_NEXT(a_compute_gives_beat, clock, reset, compute, y_vld_ff, "computed sample did not reach result register")
   `IIRF_ASSERT_NEXT(a_input_history_shift, clock, reset, compute, xh_ff[0] == $past(x_ff), "input history did not take the sample")
   `IIRF_ASSERT_SAME(a_result_matches_history, clock, reset, y_vld_ff, y_ff == yh_ff[0], "pending result differs from newest output history")
   `IIRF_ASSERT_NEXT(a_no_phantom_beat, clock, reset, !x_vld_ff && !y_vld_ff, !y_vld_ff, "result valid without a sample")

endmodule
